// File: hw/rtl/iterated_murmur3_hash_unit_assert.svh
// Assertion macros for the iterated hash unit.
`ifndef ITERATED_MURMUR3_HASH_UNIT_ASSERT_SVH
`define ITERATED_MURMUR3_HASH_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/imh_pkg.sv
// Types, constants and helper functions shared by the iterated hash unit.
package imh_pkg;

  localparam int MAX_ROUNDS_DEF   = 8;
  localparam int STAGES_PER_ROUND = 5;
  localparam int ROUNDS_W         = 4;
  localparam int ADDR_W           = 3;

  // Register index decoded from the word address bit.
  localparam logic REG_ROUNDS = 1'b0;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 4'd4;

  localparam logic [31:0] MH_SEED = 32'd312779;
  localparam logic [31:0] MH_MUL1 = 32'hcc9e2d51;
  localparam logic [31:0] MH_MUL2 = 32'h1b873593;
  localparam logic [31:0] MH_ADD  = 32'he6546b64;
  localparam logic [31:0] MH_FIN1 = 32'h85ebca6b;
  localparam logic [31:0] MH_FIN2 = 32'hc2b2ae35;
  localparam logic [31:0] MH_LEN  = 32'd4;
  localparam logic [31:0] MH_MUL5 = 32'd5;

  typedef struct packed {
    logic [31:0] key;
    logic        last_key;
  } in_item_t;

  typedef struct packed {
    logic [31:0] hash;
    logic        last_hash;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic        active;
    logic        last;
    logic [31:0] data;
  } imh_stage_t;

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

endpackage

// File: hw/rtl/imh_round.sv
// One hash round split into five register stages; inactive items pass through.
module imh_round (
  input  logic               clk,
  input  logic               rst,
  input  imh_pkg::imh_stage_t rin,
  input  logic               active,
  output imh_pkg::imh_stage_t rout
);
  import imh_pkg::*;

  imh_stage_t st [STAGES_PER_ROUND];
  imh_stage_t nxt [STAGES_PER_ROUND];

  function automatic logic [31:0] mix_k1(input logic [31:0] d);
    return d * MH_MUL1;
  endfunction

  function automatic logic [31:0] mix_k2(input logic [31:0] d);
    return rotl15(d) * MH_MUL2;
  endfunction

  function automatic logic [31:0] mix_h(input logic [31:0] d);
    logic [31:0] h;
    h = rotl13(MH_SEED ^ d);
    return h * MH_MUL5 + MH_ADD;
  endfunction

  function automatic logic [31:0] fin_a(input logic [31:0] d);
    logic [31:0] h;
    h = d ^ MH_LEN;
    h = h ^ (h >> 16);
    return h * MH_FIN1;
  endfunction

  function automatic logic [31:0] fin_b(input logic [31:0] d);
    logic [31:0] h;
    h = d ^ (d >> 13);
    h = h * MH_FIN2;
    return h ^ (h >> 16);
  endfunction

  always_comb begin
    nxt[0]        = rin;
    nxt[0].active = active;
    nxt[0].data   = active ? mix_k1(rin.data) : rin.data;
    for (int j = 1; j < STAGES_PER_ROUND; j++) begin
      nxt[j] = st[j-1];
    end
    if (st[0].active) nxt[1].data = mix_k2(st[0].data);
    if (st[1].active) nxt[2].data = mix_h(st[1].data);
    if (st[2].active) nxt[3].data = fin_a(st[2].data);
    if (st[3].active) nxt[4].data = fin_b(st[3].data);
  end

  // Only the valid bits are reset; the data fields simply follow them.
  always_ff @(posedge clk) begin
    for (int j = 0; j < STAGES_PER_ROUND; j++) begin
      if (rst) begin
        st[j].valid <= 1'b0;
      end else begin
        st[j].valid <= nxt[j].valid;
      end
      st[j].active <= nxt[j].active;
      st[j].last   <= nxt[j].last;
      st[j].data   <= nxt[j].data;
    end
  end

  assign rout = st[STAGES_PER_ROUND-1];

endmodule

// File: hw/rtl/iterated_murmur3_hash_unit.sv
// Top level of the iterated hash unit: register port, round chain, result drive.
// Every key passes through all MAX_ROUNDS round units, whatever rounds holds.
// Throughput is one key per cycle; busy stays low and the strobe cannot be held off.
// The pipeline is a chain of MAX_ROUNDS round units of five stages each.
// Synchronous reset empties the pipeline and sets rounds to 4.
`include "iterated_murmur3_hash_unit_assert.svh"

module iterated_murmur3_hash_unit #(
  parameter int MAX_ROUNDS = imh_pkg::MAX_ROUNDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  imh_pkg::in_item_t          item,
  output logic                       done,
  output imh_pkg::out_item_t         result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [imh_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import imh_pkg::*;

  logic [ROUNDS_W-1:0] rounds;
  logic                cfg_wr;
  imh_stage_t          chain [MAX_ROUNDS+1];
  logic                round_on [MAX_ROUNDS];

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ROUNDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      rounds <= ROUNDS_RESET;
    end else if (cfg_wr) begin
      rounds <= pwdata[ROUNDS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROUNDS) ? {{(32-ROUNDS_W){1'b0}}, rounds} : 32'd0;

  assign chain[0] = '{valid: start && !busy, active: 1'b0,
                      last: item.last_key, data: item.key};

  // Only MAX_ROUNDS units exist, so larger counts saturate on their own.
  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_round
    assign round_on[i] = int'(rounds) > i;

    imh_round u_round (
      .clk    (clk),
      .rst    (rst),
      .rin    (chain[i]),
      .active (round_on[i]),
      .rout   (chain[i+1])
    );

    `ASSERT_IMPLIES(a_round_delay, clk, rst, chain[i+1].valid, $past(chain[i].valid, STAGES_PER_ROUND))
    `ASSERT_IMPLIES(a_round_active, clk, rst, chain[i+1].valid, chain[i+1].active == $past(round_on[i], STAGES_PER_ROUND))
  end

  assign done   = chain[MAX_ROUNDS].valid;
  assign result = '{hash: chain[MAX_ROUNDS].data, last_hash: chain[MAX_ROUNDS].last};

  `ASSERT_NEXT(a_cfg_write, clk, rst, cfg_wr, rounds == $past(pwdata[ROUNDS_W-1:0]))

endmodule
